// ===== src/swr_pkg.sv =====
// Shared types and constants of the sort-with-rank unit.
// Used by the channel interfaces and by every module of the unit; no dependencies.
package swr_pkg;

  localparam int DATA_W      = 32;
  localparam int RANK_W      = 6;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [DATA_W-1:0] value_t;
  typedef logic [RANK_W-1:0]        rank_t;

  // One queued item after classification by the front end.
  typedef struct packed {
    value_t value;
    logic   last;
    logic   keep;
  } item_t;

  // Queue status seen by the front end and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_COPY,
    B_ALIGN,
    B_EMIT
  } back_state_e;

endpackage

// ===== src/swr_in_if.sv =====
// Input channel of the sort-with-rank unit: valid/ready handshake and item payload.
// Depends on swr_pkg.
interface swr_in_if;
  logic            valid;
  logic            ready;
  swr_pkg::value_t value;
  logic            last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

// ===== src/swr_out_if.sv =====
// Result channel of the sort-with-rank unit: valid/ready handshake and result payload.
// Depends on swr_pkg.
interface swr_out_if;
  logic            valid;
  logic            ready;
  swr_pkg::value_t sorted_value;
  swr_pkg::rank_t  rank;
  logic            overflowed;
  logic            last_result;

  modport source (output valid, output sorted_value, output rank, output overflowed,
                  output last_result, input ready);
  modport sink   (input valid, input sorted_value, input rank, input overflowed,
                  input last_result, output ready);
endinterface

// ===== src/swr_front.sv =====
// Front end of the sort-with-rank unit: takes input transfers and marks each item
// as kept or dropped. Depends on swr_pkg and swr_in_if.
module swr_front #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  swr_in_if.sink                 in_i,
  input  swr_pkg::queue_status_t qstat_i,
  output logic                   push_valid_o,
  output swr_pkg::item_t         push_item_o
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] set_cnt_q, set_cnt_d;
  logic             accept;
  logic             keep;

  assign in_i.ready   = !qstat_i.full;
  assign accept       = in_i.valid && in_i.ready;
  assign keep         = set_cnt_q < CNT_W'(MAX_ITEMS);
  assign push_valid_o = accept;

  always_comb begin
    push_item_o.value = in_i.value;
    push_item_o.last  = in_i.last_item;
    push_item_o.keep  = keep;
  end

  // Kept items in the open set; a closing item starts a new set.
  always_comb begin
    set_cnt_d = set_cnt_q;
    priority if (!accept) begin
      set_cnt_d = set_cnt_q;
    end else if (in_i.last_item) begin
      set_cnt_d = '0;
    end else if (keep) begin
      set_cnt_d = set_cnt_q + 1'b1;
    end else begin
      set_cnt_d = set_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_cnt_q <= '0;
    end else begin
      set_cnt_q <= set_cnt_d;
    end
  end

endmodule

// ===== src/swr_fifo.sv =====
// Short queue between the front and back ends of the sort-with-rank unit.
// Depends on swr_pkg.
module swr_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  input  swr_pkg::item_t         push_item_i,
  output swr_pkg::queue_status_t status_o,
  output logic                   pop_valid_o,
  output swr_pkg::item_t         pop_item_o,
  input  logic                   pop_ready_i
);

  localparam int DEPTH = swr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  swr_pkg::item_t   entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign status_o.full  = cnt_q == CNT_W'(DEPTH);
  assign status_o.empty = cnt_q == '0;
  assign pop_valid_o    = !status_o.empty;
  assign pop_item_o     = entries_q[rd_ptr_q];

  // The front end only offers an item when the queue has room.
  assign push = push_valid_i;
  assign pop  = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/swr_back.sv =====
// Back end of the sort-with-rank unit: stores the set, keeps it sorted by insertion,
// then emits sorted values with ranks. Depends on swr_pkg and swr_out_if.
module swr_back #(
  parameter int MAX_ITEMS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           sort_descending_i,
  input  logic           pop_valid_i,
  input  swr_pkg::item_t pop_item_i,
  output logic           pop_ready_o,
  swr_out_if.source      out_o
);

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int STEP_W = $clog2(IDX_W + 1);

  swr_pkg::back_state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  amt_q, amt_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  amt_full;

  swr_pkg::value_t   mem [MAX_ITEMS];
  swr_pkg::value_t   rd_q;
  logic [IDX_W-1:0]  rd_addr;

  swr_pkg::value_t   row_q [MAX_ITEMS];
  swr_pkg::value_t   row_d [MAX_ITEMS];
  swr_pkg::value_t   shd_q [MAX_ITEMS];
  swr_pkg::value_t   shd_d [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] ins;

  logic [MAX_ITEMS-1:0] cond;
  logic [MAX_ITEMS-1:0] first;
  logic [CNT_W-1:0]     f_enc;
  logic [CNT_W-1:0]     f_pos;
  logic [CNT_W-1:0]     rank_full;

  logic              out_valid_q, out_valid_d;
  swr_pkg::value_t   out_value_q;
  swr_pkg::rank_t    out_rank_q;
  logic              out_ovf_q;
  logic              out_last_q;

  logic load_fire;
  logic emit_fire;
  logic emit_last;
  logic align_done;

  // ---------------- control outputs of the state machine ----------------
  always_comb begin
    pop_ready_o = state_q == swr_pkg::B_LOAD;
    load_fire   = pop_valid_i && pop_ready_o;
    emit_fire   = (state_q == swr_pkg::B_EMIT) && (!out_valid_q || out_o.ready);
    emit_last   = emit_fire && ((CNT_W'(idx_q) + 1'b1) == cnt_q);
    align_done  = step_q == STEP_W'(IDX_W - 1);
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swr_pkg::B_LOAD: begin
        if (load_fire && pop_item_i.last) state_d = swr_pkg::B_COPY;
      end
      swr_pkg::B_COPY: begin
        state_d = sort_descending_i ? swr_pkg::B_ALIGN : swr_pkg::B_EMIT;
      end
      swr_pkg::B_ALIGN: begin
        if (align_done) state_d = swr_pkg::B_EMIT;
      end
      swr_pkg::B_EMIT: begin
        if (emit_last) state_d = swr_pkg::B_LOAD;
      end
    endcase
  end

  // ---------------- sorted row: insertion of one kept value per cycle ----------------
  always_comb begin
    for (int k = 0; k < MAX_ITEMS; k++) begin
      ins[k] = (CNT_W'(k) >= cnt_q) || (pop_item_i.value < row_q[k]);
    end
    for (int k = 0; k < MAX_ITEMS; k++) begin
      row_d[k] = row_q[k];
      if (load_fire && pop_item_i.keep && ins[k]) begin
        if (k == 0) begin
          row_d[k] = pop_item_i.value;
        end else if (!ins[k-1]) begin
          row_d[k] = pop_item_i.value;
        end else begin
          row_d[k] = row_q[k-1];
        end
      end
    end
  end

  // ---------------- counters and emission row ----------------
  assign amt_full = CNT_W'(MAX_ITEMS) - cnt_q;

  always_comb begin
    cnt_d  = cnt_q;
    drop_d = drop_q;
    idx_d  = idx_q;
    amt_d  = amt_q;
    step_d = step_q;
    for (int k = 0; k < MAX_ITEMS; k++) begin
      shd_d[k] = shd_q[k];
    end

    unique case (state_q)
      swr_pkg::B_LOAD: begin
        if (load_fire) begin
          if (pop_item_i.keep) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      swr_pkg::B_COPY: begin
        // Descending order is the ascending row reversed, then moved down to cell 0.
        for (int k = 0; k < MAX_ITEMS; k++) begin
          shd_d[k] = sort_descending_i ? row_q[MAX_ITEMS-1-k] : row_q[k];
        end
        amt_d  = amt_full[IDX_W-1:0];
        step_d = '0;
        idx_d  = '0;
      end
      swr_pkg::B_ALIGN: begin
        for (int s = 0; s < IDX_W; s++) begin
          if (step_q == STEP_W'(s) && amt_q[0]) begin
            for (int k = 0; k < MAX_ITEMS; k++) begin
              if (k + (1 << s) < MAX_ITEMS) shd_d[k] = shd_q[k + (1 << s)];
            end
          end
        end
        amt_d  = amt_q >> 1;
        step_d = step_q + 1'b1;
      end
      swr_pkg::B_EMIT: begin
        if (emit_fire) begin
          for (int k = 0; k < MAX_ITEMS - 1; k++) begin
            shd_d[k] = shd_q[k+1];
          end
          idx_d = idx_q + 1'b1;
          if (emit_last) begin
            cnt_d  = '0;
            drop_d = 1'b0;
            idx_d  = '0;
          end
        end
      end
    endcase
  end

  // ---------------- rank of the loaded value at the current index ----------------
  // The row is ascending, so the compare vector is a run of zeros then ones;
  // the first one marks the boundary that gives the rank.
  always_comb begin
    for (int k = 0; k < MAX_ITEMS; k++) begin
      cond[k] = (CNT_W'(k) >= cnt_q) ||
                (sort_descending_i ? (row_q[k] > rd_q) : !(row_q[k] < rd_q));
    end
    f_enc = '0;
    for (int k = 0; k < MAX_ITEMS; k++) begin
      first[k] = cond[k] && ((k == 0) || !cond[k-1]);
      f_enc    = f_enc | (first[k] ? CNT_W'(k) : '0);
    end
    f_pos     = (|first) ? f_enc : CNT_W'(MAX_ITEMS);
    rank_full = sort_descending_i ? (cnt_q - f_pos) : f_pos;
  end

  assign rd_addr     = emit_fire ? idx_q + 1'b1 : idx_q;
  assign out_valid_d = emit_fire || (out_valid_q && !out_o.ready);

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swr_pkg::B_LOAD;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      amt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      idx_q       <= idx_d;
      amt_q       <= amt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_ITEMS; k++) begin
      row_q[k] <= row_d[k];
      shd_q[k] <= shd_d[k];
    end
    if (emit_fire) begin
      out_value_q <= shd_q[0];
      out_rank_q  <= swr_pkg::RANK_W'(rank_full);
      out_ovf_q   <= drop_q;
      out_last_q  <= emit_last;
    end
  end

  // Load-order store: one write while loading, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (load_fire && pop_item_i.keep) begin
      mem[cnt_q[IDX_W-1:0]] <= pop_item_i.value;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.rank         = out_rank_q;
  assign out_o.overflowed   = out_ovf_q;
  assign out_o.last_result  = out_last_q;

endmodule

// ===== src/sort_with_rank_unit.sv =====
// Top level of the sort-with-rank unit: configuration register, front end, queue
// and back end. Depends on swr_pkg, swr_in_if, swr_out_if, swr_front, swr_fifo, swr_back.
//
//   Channel  | Direction | Transfer carries
//   ---------+-----------+----------------------------------------------------
//   in_i     | in        | value (signed 32), last_item
//   out_o    | out       | sorted_value (signed 32), rank (6), overflowed, last_result
//   cfg      | in        | cfg_we_i with cfg_wdata_i = sort_descending
//
// Transfers load as they arrive; the back end inserts each kept value into a sorted
// register row in the cycle it leaves the queue. Closing a set passes the copy state
// and, in descending order, the align state, then gives one result per cycle while
// out_o is ready, limited by the single registered read port of the load-order store.
// Reset clears the set count, the overflow flag, the order register and all handshake
// state; stored values need no reset. While a set is being emitted the back end takes
// no items, and the front end keeps accepting until the four-entry queue is full.
module sort_with_rank_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swr_in_if.sink    in_i,
  swr_out_if.source out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  localparam int RankW = swr_pkg::RANK_W;
  localparam logic [RankW-1:0] RANK_MAX = RankW'(MAX_ITEMS - 1);

  // Sort order register: 0 ascending, 1 descending.
  logic sort_desc_q;

  // Queue hookup between the two halves.
  logic                   push_valid;
  swr_pkg::item_t         push_item;
  swr_pkg::queue_status_t qstat;
  logic                   pop_valid;
  logic                   pop_ready;
  swr_pkg::item_t         pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      sort_desc_q <= cfg_wdata_i;
    end
  end

  // The front end tags every item as kept or dropped, so the back end never has to
  // reason about capacity beyond its own write count.
  swr_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .qstat_i      (qstat),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  swr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .status_o     (qstat),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // The back end owns the load-order store, the sorted row and the result register.
  swr_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sort_descending_i (sort_desc_q),
    .pop_valid_i       (pop_valid),
    .pop_item_i        (pop_item),
    .pop_ready_o       (pop_ready),
    .out_o             (out_o)
  );

  // All results of one set carry the same overflow flag.
  a_ovf_per_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_result |=>
      !out_o.valid || (out_o.overflowed == $past(out_o.overflowed)))
    else $error("overflow flag changed inside one set");

  // A rank never exceeds the largest position of a full set, MAX_ITEMS - 1.
  a_rank_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.rank <= RANK_MAX)
    else $error("rank beyond capacity");

  // A full queue always offers an item to the back end and refuses new input.
  a_queue_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> pop_valid && !in_i.ready)
    else $error("queue status disagrees with handshakes");

endmodule
